// ----- rtl/cwm_pkg.sv -----
// Shared constants for the clipped window median filter.
// Depends on nothing; imported by the top level.
package cwm_pkg;
  localparam int MAX_RADIUS = 3;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int SLOTS      = 2 * MAX_RADIUS + 1;
  localparam int WIN        = SLOTS * SLOTS;
  localparam int LS_DEPTH   = SLOTS * MAX_WIDTH;
  localparam int LS_AW      = $clog2(LS_DEPTH);
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int CNT_W      = $clog2(WIN + 1);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int WREG_W     = 11;
  localparam int HREG_W     = 13;
  localparam int OUT_W      = 48;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  // index with no register behind it; writes to it are dropped
  localparam logic [1:0] REG_NONE   = 2'd3;
endpackage

// ----- rtl/cwm_ram.sv -----
// Generic simple dual-port RAM with registered read.
// Depends on nothing; used for the line store.
module cwm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 7168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/clipped_window_median_filter.sv -----
// Top level of the clipped window RGB median filter.
// Depends on cwm_pkg and cwm_ram.
//
// RGB pixels enter in raster order, one word per handshake, and land in a
// line store of seven rows. Each accepted pixel emits every result whose
// clipped window it completes (none, one, or a burst of up to sixteen at
// row and frame ends), each tagged with its column and row; tlast marks the
// last result of a burst and tuser the frame's bottom-right pixel. Per
// result the window (n pixels, up to 49) is read from the line store one
// pixel per cycle through the single read port, then a bit-serial rank
// selection resolves one median bit per cycle, all three channels at once:
// one pass for odd n, two passes for even n (two middle ranks, then their
// floor mean). The next pixel is taken once all results of the current one
// have been handed to the output register; a result may still wait there.
// Configuration writes restart the frame at the top-left pixel and are taken
// at any time; issue them only while the block is idle.
module clipped_window_median_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cwm_pkg::PIX_W-1:0]     in_tdata,   // pixel_red, pixel_green, pixel_blue
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cwm_pkg::OUT_W-1:0]     out_tdata,  // median_red, median_green,
                                                    // median_blue, out_col, out_row, pad
  output logic                          out_tlast,  // last_of_run
  output logic                          out_tuser,  // frame_done
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [cwm_pkg::HREG_W-1:0]    cfg_data
);
  import cwm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_SEL   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        radius_r;
  logic [WREG_W-1:0] width_r;
  logic [HREG_W-1:0] height_r;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [SLOT_W-1:0] in_slot_r, in_slot_nxt;

  // burst bookkeeping
  logic [ROW_W-1:0]  cur_row_r;
  logic [SLOT_W-1:0] cur_slot_r;
  logic [COL_W-1:0]  rx_r, xlo_r, xhi_r;
  logic [ROW_W-1:0]  ry_r, yhi_r;
  // window walk
  logic [COL_W-1:0]  x0_r, x1_r, xx_r;
  logic [ROW_W-1:0]  y1_r, yy_r;
  logic              cap_r;
  logic [CNT_W-1:0]  n_r;
  logic [PIX_W-1:0]  win_r [WIN];
  // rank selection per channel
  logic [WIN-1:0]    act_r [3];
  logic [CNT_W-1:0]  k_r   [3];
  logic [CH_W-1:0]   acc_r [3];
  logic [CH_W-1:0]   resa_r[3];
  logic [CH_W-1:0]   med_r [3];
  logic [2:0]        bit_r;
  logic              pass_r;

  logic [OUT_W-1:0]  out_tdata_r;
  logic              out_tvalid_r, out_tlast_r, out_tuser_r;

  // effective geometry
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;
  logic [COL_W-1:0]  wm1, r_c;
  logic [ROW_W-1:0]  hm1, r_r;

  always_comb begin
    if (width_r == '0) w_eff = WREG_W'(1);
    else if (width_r > WREG_W'(MAX_WIDTH)) w_eff = WREG_W'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = HREG_W'(1);
    else if (height_r > HREG_W'(MAX_HEIGHT)) h_eff = HREG_W'(MAX_HEIGHT);
    else h_eff = height_r;
    wm1 = COL_W'(w_eff - WREG_W'(1));
    hm1 = ROW_W'(h_eff - HREG_W'(1));
    r_c = COL_W'(radius_r);
    r_r = ROW_W'(radius_r);
  end

  // accept path: position of the arriving pixel and the burst it completes
  logic              acc_in, pos_ok, hx, hy, cfg_wr;
  logic [COL_W-1:0]  c, xlo, xhi;
  logic [ROW_W-1:0]  rw, ylo, yhi;
  logic [SLOT_W-1:0] sl;

  assign in_tready = (state_r == S_IDLE);
  assign acc_in    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready &&
                     (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                      cfg_index == REG_HEIGHT);

  always_comb begin
    pos_ok = (in_col_r <= wm1) && (in_row_r <= hm1);
    c  = pos_ok ? in_col_r  : '0;
    rw = pos_ok ? in_row_r  : '0;
    sl = pos_ok ? in_slot_r : '0;
    if (c == wm1) begin
      xlo = (c >= r_c) ? c - r_c : '0;
      xhi = c;
      hx  = 1'b1;
    end else begin
      hx  = (c >= r_c);
      xlo = hx ? c - r_c : '0;
      xhi = xlo;
    end
    if (rw == hm1) begin
      ylo = (rw >= r_r) ? rw - r_r : '0;
      yhi = rw;
      hy  = 1'b1;
    end else begin
      hy  = (rw >= r_r);
      ylo = hy ? rw - r_r : '0;
      yhi = ylo;
    end
    in_col_nxt  = c + COL_W'(1);
    in_row_nxt  = rw;
    in_slot_nxt = sl;
    if (c == wm1) begin
      in_col_nxt = '0;
      if (rw == hm1) begin
        in_row_nxt  = '0;
        in_slot_nxt = '0;
      end else begin
        in_row_nxt  = rw + ROW_W'(1);
        in_slot_nxt = (sl == SLOT_W'(SLOTS - 1)) ? '0 : sl + SLOT_W'(1);
      end
    end
  end

  // window bounds of the current result
  logic [COL_W-1:0] x0, x1;
  logic [ROW_W-1:0] y0, y1;
  logic [COL_W:0]   xr_sum;
  logic [ROW_W:0]   yr_sum;

  always_comb begin
    xr_sum = {1'b0, rx_r} + {1'b0, r_c};
    yr_sum = {1'b0, ry_r} + {1'b0, r_r};
    x0 = (rx_r >= r_c) ? rx_r - r_c : '0;
    y0 = (ry_r >= r_r) ? ry_r - r_r : '0;
    x1 = (xr_sum < {1'b0, wm1}) ? COL_W'(xr_sum) : wm1;
    y1 = (yr_sum < {1'b0, hm1}) ? ROW_W'(yr_sum) : hm1;
  end

  // line store addressing: row slot found by stepping back from the
  // current row's slot
  logic [SLOT_W-1:0] dlt, rslot;
  logic [SLOT_W:0]   wrap;
  logic [LS_AW-1:0]  raddr, waddr;
  logic [PIX_W-1:0]  rd_data;

  always_comb begin
    dlt   = SLOT_W'(cur_row_r - yy_r);
    wrap  = {1'b0, cur_slot_r} + (SLOT_W + 1)'(SLOTS) - {1'b0, dlt};
    rslot = (cur_slot_r >= dlt) ? cur_slot_r - dlt : SLOT_W'(wrap);
    raddr = LS_AW'(rslot) * LS_AW'(MAX_WIDTH) + LS_AW'(xx_r);
    waddr = LS_AW'(sl) * LS_AW'(MAX_WIDTH) + LS_AW'(c);
  end

  cwm_ram #(
    .WIDTH(PIX_W),
    .DEPTH(LS_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (acc_in),
    .waddr(waddr),
    .wdata(in_tdata),
    .re   (state_r == S_READ),
    .raddr(raddr),
    .rdata(rd_data)
  );

  // bit-serial rank step: one median bit per channel per cycle
  logic [WIN-1:0]   msb [3];
  logic [WIN-1:0]   zeros [3];
  logic [CNT_W-1:0] cnt [3];
  logic [WIN-1:0]   act_nxt [3];
  logic [CNT_W-1:0] k_nxt [3];
  logic [CH_W-1:0]  acc_nxt [3];
  logic [CH_W:0]    mean_sum [3];
  logic [WIN-1:0]   vmask;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      vmask[i] = (CNT_W'(i) < n_r);
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WIN; i++) begin
        msb[ch][i] = win_r[i][ch * CH_W + CH_W - 1];
      end
      zeros[ch] = act_r[ch] & ~msb[ch];
      cnt[ch]   = CNT_W'($countones(zeros[ch]));
      if (k_r[ch] < cnt[ch]) begin
        act_nxt[ch] = zeros[ch];
        k_nxt[ch]   = k_r[ch];
        acc_nxt[ch] = {acc_r[ch][CH_W-2:0], 1'b0};
      end else begin
        act_nxt[ch] = act_r[ch] & msb[ch];
        k_nxt[ch]   = k_r[ch] - cnt[ch];
        acc_nxt[ch] = {acc_r[ch][CH_W-2:0], 1'b1};
      end
      mean_sum[ch] = {1'b0, resa_r[ch]} + {1'b0, acc_nxt[ch]};
    end
  end

  logic last_res;
  logic out_load;
  assign last_res = (rx_r == xhi_r) && (ry_r == yhi_r);
  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc_in && hx && hy) state_nxt = S_START;
      S_START: state_nxt = S_READ;
      S_READ:  if (xx_r == x1_r && yy_r == y1_r) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_SEL;
      S_SEL:   if (bit_r == 3'd7 && (pass_r || n_r[0])) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = last_res ? S_IDLE : S_START;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      radius_r     <= 2'd1;
      width_r      <= WREG_W'(1024);
      height_r     <= HREG_W'(768);
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_slot_r    <= '0;
      cap_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= (state_r == S_READ);
      // a write to a listed register restarts the frame
      if (cfg_wr) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        in_slot_r <= '0;
        case (cfg_index)
          REG_RADIUS: radius_r <= cfg_data[1:0];
          REG_WIDTH:  width_r  <= cfg_data[WREG_W-1:0];
          REG_HEIGHT: height_r <= cfg_data;
          default:    ;
        endcase
      end else if (acc_in) begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        in_slot_r <= in_slot_nxt;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (acc_in) begin
      rx_r       <= xlo;
      ry_r       <= ylo;
      xlo_r      <= xlo;
      xhi_r      <= xhi;
      yhi_r      <= yhi;
      cur_row_r  <= rw;
      cur_slot_r <= sl;
    end
    if (state_r == S_START) begin
      x0_r <= x0;
      x1_r <= x1;
      y1_r <= y1;
      xx_r <= x0;
      yy_r <= y0;
      n_r  <= '0;
    end
    if (state_r == S_READ) begin
      if (xx_r == x1_r) begin
        xx_r <= x0_r;
        yy_r <= yy_r + ROW_W'(1);
      end else begin
        xx_r <= xx_r + COL_W'(1);
      end
    end
    // shift each fetched pixel into the window line
    if (cap_r) begin
      win_r[0] <= rd_data;
      for (int i = 1; i < WIN; i++) begin
        win_r[i] <= win_r[i-1];
      end
      n_r <= n_r + CNT_W'(1);
    end else if (state_r == S_SEL) begin
      // rotate every channel so the next bit sits at the top
      for (int i = 0; i < WIN; i++) begin
        for (int ch = 0; ch < 3; ch++) begin
          win_r[i][ch*CH_W +: CH_W] <= {win_r[i][ch*CH_W +: CH_W-1],
                                        win_r[i][ch*CH_W + CH_W - 1]};
        end
      end
    end
    if (state_r == S_SETUP) begin
      bit_r  <= '0;
      pass_r <= 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
        act_r[ch] <= vmask;
        k_r[ch]   <= (n_r - CNT_W'(1)) >> 1;
        acc_r[ch] <= '0;
      end
    end
    if (state_r == S_SEL) begin
      bit_r <= bit_r + 3'd1;
      if (bit_r == 3'd7 && !pass_r && !n_r[0]) begin
        // even count: select the upper middle rank next
        pass_r <= 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
          act_r[ch] <= vmask;
          k_r[ch]   <= n_r >> 1;
          acc_r[ch] <= '0;
        end
      end else begin
        for (int ch = 0; ch < 3; ch++) begin
          act_r[ch] <= act_nxt[ch];
          k_r[ch]   <= k_nxt[ch];
          acc_r[ch] <= acc_nxt[ch];
        end
      end
      if (bit_r == 3'd7) begin
        if (!pass_r) begin
          for (int ch = 0; ch < 3; ch++) begin
            resa_r[ch] <= acc_nxt[ch];
            med_r[ch]  <= acc_nxt[ch];
          end
        end else begin
          for (int ch = 0; ch < 3; ch++) begin
            med_r[ch] <= mean_sum[ch][CH_W:1];
          end
        end
      end
    end
    if (out_load) begin
      out_tdata_r <= {2'b00, ry_r, rx_r, med_r[2], med_r[1], med_r[0]};
      out_tlast_r <= last_res;
      out_tuser_r <= (rx_r == wm1) && (ry_r == hm1);
      if (rx_r == xhi_r) begin
        rx_r <= xlo_r;
        ry_r <= ry_r + ROW_W'(1);
      end else begin
        rx_r <= rx_r + COL_W'(1);
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // the window line never holds more pixels than it has stages
  a_win_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP) |-> (n_r <= CNT_W'(WIN)))
    else $error("window fill count overflow");

  // the rank sought in the red channel always lies among the remaining candidates
  a_rank_red: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL) |-> (k_r[0] < cnt[0] + CNT_W'($countones(act_r[0] & msb[0]))))
    else $error("rank lost in red selection");

  // the bottom-right pixel is always the final result of its burst
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame end not at end of burst");
`endif
endmodule

// ----- sim/tb.sv -----
// Self-checking bench for the clipped window median filter.
// Depends on rtl/cwm_pkg.sv and rtl/clipped_window_median_filter.sv.
// It predicts every burst from a local frame store and checks each output word.
module tb;
  import cwm_pkg::*;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
    logic             done;
  } median_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [PIX_W-1:0]    in_tdata;   // pixel_red, pixel_green, pixel_blue
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;  // median_red, median_green, median_blue, col, row, pad
  logic                out_tlast;  // last_of_run
  logic                out_tuser;  // frame_done
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [HREG_W-1:0]   cfg_data;

  clipped_window_median_filter u_top (.*);

  // Pixels waiting to be sent and medians waiting to come out.
  logic [PIX_W-1:0] pixel_q[$];
  median_t          median_q[$];
  int               fails = 0;

  // Shadow of the block: registers, input position and frame store.
  logic [1:0]        radius_reg = 2'd1;
  logic [WREG_W-1:0] width_reg  = 11'd1024;
  logic [HREG_W-1:0] height_reg = 13'd768;
  int                cur_col = 0, cur_row = 0;
  logic [PIX_W-1:0]  frame_store [LS_DEPTH];

  // Phase controls, written only by the sequencer.
  logic no_idle  = 1'b0;
  logic hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(40_000_000);
    $display("clipped_window_median_filter: mismatch");
    $finish;
  end

  // Median of one channel over the clipped window around (x,y).
  function automatic logic [7:0] chan_median(int x, int y, int r, int w, int h, int sh);
    int vals[WIN];
    int n, t, j, x0, x1, y0, y1;
    n = 0;
    x0 = (x >= r) ? x - r : 0;
    y0 = (y >= r) ? y - r : 0;
    x1 = (x + r < w - 1) ? x + r : w - 1;
    y1 = (y + r < h - 1) ? y + r : h - 1;
    for (int yy = y0; yy <= y1; yy++)
      for (int xx = x0; xx <= x1; xx++) begin
        vals[n] = (frame_store[(yy % SLOTS) * MAX_WIDTH + xx] >> sh) & 8'hff;
        n++;
      end
    for (int i = 1; i < n; i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > t) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = t;
    end
    if (n % 2) return 8'(vals[n/2]);
    return 8'((vals[n/2-1] + vals[n/2]) / 2);
  endfunction

  // Store one accepted pixel and queue every median it completes.
  task automatic predict_pixel(logic [PIX_W-1:0] px);
    int r, w, h, c, rw, xlo, xhi, ylo, yhi;
    bit hx, hy;
    median_t m;
    r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    if (cur_col >= w || cur_row >= h) begin
      cur_col = 0;
      cur_row = 0;
    end
    c = cur_col;
    rw = cur_row;
    // Keep {red,green,blue} with red in the top byte to match the channel shifts.
    frame_store[(rw % SLOTS) * MAX_WIDTH + c] = {px[7:0], px[15:8], px[23:16]};
    if (c == w - 1) begin
      xlo = (c >= r) ? c - r : 0; xhi = c; hx = 1;
    end else begin
      hx = (c >= r); xlo = hx ? c - r : 0; xhi = xlo;
    end
    if (rw == h - 1) begin
      ylo = (rw >= r) ? rw - r : 0; yhi = rw; hy = 1;
    end else begin
      hy = (rw >= r); ylo = hy ? rw - r : 0; yhi = ylo;
    end
    if (hx && hy)
      for (int y = ylo; y <= yhi; y++)
        for (int x = xlo; x <= xhi; x++) begin
          m.red   = chan_median(x, y, r, w, h, 16);
          m.green = chan_median(x, y, r, w, h, 8);
          m.blue  = chan_median(x, y, r, w, h, 0);
          m.col   = COL_W'(x);
          m.row   = ROW_W'(y);
          m.last  = (x == xhi && y == yhi);
          m.done  = (x == w - 1 && y == h - 1);
          median_q = {median_q, m};
        end
    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = rw + 1;
      if (cur_row >= h) cur_row = 0;
    end
  endtask

  // Pixel driver: hold a word until taken, then wait a random gap.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_pixel(in_tdata);
        in_gap = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered word
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_tdata  <= pixel_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each taken word with the oldest prediction.
  int out_gap = 0, hold_cnt = 0;
  bit hold_done = 0;
  median_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.red   = out_tdata[7:0];
        got.green = out_tdata[15:8];
        got.blue  = out_tdata[23:16];
        got.col   = out_tdata[33:24];
        got.row   = out_tdata[45:34];
        got.last  = out_tlast;
        got.done  = out_tuser;
        if (median_q.size() == 0) begin
          $display("%0t: unexpected word col %0d row %0d", $time, got.col, got.row);
          fails++;
        end else begin
          want = median_q.pop_front();
          if (got != want) begin
            $display("%0t: expected r%0d g%0d b%0d c%0d y%0d l%0b f%0b", $time,
                     want.red, want.green, want.blue, want.col, want.row,
                     want.last, want.done);
            $display("%0t: actual   r%0d g%0d b%0d c%0d y%0d l%0b f%0b", $time,
                     got.red, got.green, got.blue, got.col, got.row,
                     got.last, got.done);
            fails++;
          end
        end
        out_gap = no_idle ? 0 : $urandom_range(0, 14);
      end
      // Long back-pressure once, so the input side stalls behind a full burst.
      if (hold_req && !hold_done && out_tvalid) begin
        hold_done = 1;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Write one register and mirror it in the shadow copy.
  task automatic write_reg(logic [1:0] idx, logic [HREG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_RADIUS: radius_reg = val[1:0];
      REG_WIDTH:  width_reg  = val[WREG_W-1:0];
      REG_HEIGHT: height_reg = val;
      default: ;
    endcase
    if (idx == REG_RADIUS || idx == REG_WIDTH || idx == REG_HEIGHT) begin
      cur_col = 0;
      cur_row = 0;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(int r, int w, int h);
    write_reg(REG_RADIUS, HREG_W'(r));
    write_reg(REG_WIDTH, HREG_W'(w));
    write_reg(REG_HEIGHT, HREG_W'(h));
  endtask

  // Drain: everything sent and checked, then let a trailing pixel finish.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_tvalid || median_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  int sent, r, w, h, n;
  initial begin
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    wait (rst_n === 1'b1);

    // Radius zero: each pixel is its own median.
    set_frame(0, 3, 2);
    pixel_q = '{24'h000000, 24'hffffff, 24'h00ff00, 24'hff00ff, 24'h123456, 24'hfedcba};
    wait_idle();

    // Zero width and height fall back to a one-pixel frame.
    set_frame(1, 0, 0);
    pixel_q = '{24'hffffff, 24'h000000, 24'h80ff01};
    wait_idle();

    // Largest radius; a write to an unused index must not restart the frame.
    set_frame(3, 5, 4);
    for (int i = 0; i < 7; i++) pixel_q = {pixel_q, ((i % 2) ? 24'hffffff : 24'h000000)};
    wait_idle();
    write_reg(REG_NONE, 13'h1fff);
    for (int i = 0; i < 13; i++) pixel_q = {pixel_q, rand_pixel()};
    wait_idle();

    // Oversized width saturates to a full row; send the start of the row.
    set_frame(2, 2047, 1);
    for (int i = 0; i < 40; i++) pixel_q = {pixel_q, rand_pixel()};
    wait_idle();

    // Oversized height saturates; send only the first rows.
    set_frame(3, 4, 8191);
    for (int i = 0; i < 20; i++) pixel_q = {pixel_q, rand_pixel()};
    wait_idle();

    // Full bursts with a long receiver stall.
    set_frame(3, 8, 7);
    hold_req = 1'b1;
    for (int i = 0; i < 56; i++) pixel_q = {pixel_q, rand_pixel()};
    wait_idle();

    // Random frames, mostly whole, sometimes cut short.
    sent = 0;
    while (sent < 60) begin
      r = $urandom_range(0, 3);
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 7);
      no_idle = ($urandom_range(0, 3) == 0);
      set_frame(r, w, h);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h) : w * h * $urandom_range(1, 2);
      for (int i = 0; i < n; i++) pixel_q = {pixel_q, rand_pixel()};
      sent += n;
      wait_idle();
    end

    if (fails == 0) begin
      $display("clipped_window_median_filter: match");
    end else begin
      $display("clipped_window_median_filter: mismatch");
    end
    $finish;
  end
endmodule
